### rtl/core/ultrasonic_range_averager_macros.svh
// Assertion macros for the ultrasonic range averager.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef ULTRASONIC_RANGE_AVERAGER_MACROS_SVH
`define ULTRASONIC_RANGE_AVERAGER_MACROS_SVH
`ifndef SYNTHESIS
`define URAV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urav: assertion failed");
`define URAV_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urav: assertion failed");
`else
`define URAV_ASSERT_IMP(name, ante, cons)
`define URAV_ASSERT_NXT(name, ante, cons)
`endif
`endif

### rtl/core/urav_pkg.sv
// Shared types and constants of the ultrasonic range averager.
// No dependencies; imported by every module of the block.
`default_nettype none

package urav_pkg;

    localparam int MM_W = 14;
    localparam logic [MM_W-1:0] MM_MAX = 14'd11299;

    // floor(c * 10 / 58) == (c * MM_RECIP) >> MM_SHIFT for every count below 2^24.
    localparam int MM_RECIP_W = 30;
    localparam logic [MM_RECIP_W-1:0] MM_RECIP = 30'd740511605;
    localparam int MM_SHIFT = 32;

    localparam int PERIOD_W = 20;
    localparam int PULSE_W = 10;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd100000;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 10'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_PERIOD = 2'd1,
        REG_PULSE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                enable;
        logic [PERIOD_W-1:0] period;
        logic [PULSE_W-1:0]  pulse;
    } trig_cfg_t;

    typedef struct packed {
        logic trig;
        logic done;
    } tick_tag_t;

endpackage

`default_nettype wire

### rtl/core/urav_trigger_gen.sv
// Periodic trigger pulse generator, advanced once per accepted tick.
// Depends on urav_pkg.
`default_nettype none

module urav_trigger_gen (
    input  logic                clk,
    input  logic                rst_n,
    input  urav_pkg::trig_cfg_t cfg,
    input  logic                step,
    output logic                trig
);
    import urav_pkg::*;

    logic [PERIOD_W-1:0] count_reg;
    logic [PERIOD_W-1:0] count_next;
    logic [PERIOD_W:0]   count_inc;

    always_comb
    begin
        count_inc  = {1'b0, count_reg} + {{PERIOD_W{1'b0}}, 1'b1};
        trig       = 1'b0;
        count_next = '0;
        if (cfg.enable)
        begin
            trig = (count_reg < {{(PERIOD_W-PULSE_W){1'b0}}, cfg.pulse});
            if (count_inc >= {1'b0, cfg.period})
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_inc[PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/urav_echo_timer.sv
// Echo edge detector and saturating pulse-width counter.
// Depends on urav_pkg.
`default_nettype none

module urav_echo_timer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   echo,
    output logic                   done,
    output logic [COUNT_WIDTH-1:0] width
);
    import urav_pkg::*;

    logic                   prev_reg;
    logic                   meas_reg;
    logic                   meas_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   at_max;

    assign width  = cnt_reg;
    assign at_max = (cnt_reg == {COUNT_WIDTH{1'b1}});

    always_comb
    begin
        meas_next = meas_reg;
        cnt_next  = cnt_reg;
        done      = 1'b0;
        unique case ({echo, prev_reg})
            2'b10:
            begin
                if (!meas_reg)
                begin
                    meas_next = 1'b1;
                    cnt_next  = COUNT_WIDTH'(1);
                end
                else if (!at_max)
                begin
                    cnt_next = cnt_reg + COUNT_WIDTH'(1);
                end
            end
            2'b11:
            begin
                if (meas_reg && !at_max)
                begin
                    cnt_next = cnt_reg + COUNT_WIDTH'(1);
                end
            end
            2'b01:
            begin
                done      = meas_reg;
                meas_next = 1'b0;
                cnt_next  = '0;
            end
            2'b00:
            begin
                meas_next = meas_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            meas_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            prev_reg <= echo;
            meas_reg <= meas_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/urav_range_conv.sv
// Pulse width to millimetre conversion by a constant reciprocal multiply.
// Depends on urav_pkg.
`default_nettype none

module urav_range_conv #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic [COUNT_WIDTH-1:0] width,
    output logic [COUNT_WIDTH-3:0] mm_raw
);
    import urav_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + MM_RECIP_W;
    localparam int RAW_W = COUNT_WIDTH - 2;

    logic [PROD_W-1:0] product;
    logic [RAW_W-1:0]  mm_raw_reg;

    assign product = PROD_W'(width) * PROD_W'(MM_RECIP);
    assign mm_raw  = mm_raw_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mm_raw_reg <= product[MM_SHIFT +: RAW_W];
        end
    end

endmodule

`default_nettype wire

### rtl/core/urav_ring_avg.sv
// Distance ring with running sum and the average by reciprocal multiply.
// Depends on urav_pkg.
`default_nettype none

module urav_ring_avg #(
    parameter int AVG_DEPTH = 10,
    parameter int RAW_W = 14
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      upd,
    input  logic                      upd_done,
    input  logic [RAW_W-1:0]          mm_raw,
    input  logic                      load_avg,
    output logic [urav_pkg::MM_W-1:0] latest,
    output logic [urav_pkg::MM_W-1:0] average
);
    import urav_pkg::*;

    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W = $clog2(AVG_DEPTH * int'(MM_MAX) + 1);
    localparam int AVG_SHIFT = SUM_W + $clog2(AVG_DEPTH) + 1;
    localparam int RECIP_W = AVG_SHIFT + 1;
    localparam int AVG_RECIP = (2**AVG_SHIFT + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int AVG_PROD_W = SUM_W + RECIP_W;
    localparam int CMP_W = (RAW_W > MM_W) ? RAW_W : MM_W;

    logic [MM_W-1:0]       ring_reg [AVG_DEPTH];
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [MM_W-1:0]       mm_sat;
    logic [CMP_W-1:0]      raw_ext;
    logic [MM_W-1:0]       mm3_reg;
    logic [MM_W-1:0]       mm4_reg;
    logic [AVG_PROD_W-1:0] avg_prod_reg;

    always_comb
    begin
        raw_ext = CMP_W'(mm_raw);
        if (raw_ext > CMP_W'(MM_MAX))
        begin
            mm_sat = MM_MAX;
        end
        else
        begin
            mm_sat = MM_W'(raw_ext);
        end
        sum_next = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(mm_sat);
        if (idx_reg == IDX_W'(AVG_DEPTH - 1))
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (upd && upd_done)
        begin
            ring_reg[idx_reg] <= mm_sat;
            idx_reg           <= idx_next;
            sum_reg           <= sum_next;
        end
    end

    // The sum register already holds the total that belongs to the item in the
    // middle stage, because it only changes when that stage advances.
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            mm3_reg <= mm_sat;
        end
        if (load_avg)
        begin
            mm4_reg      <= mm3_reg;
            avg_prod_reg <= AVG_PROD_W'(sum_reg) * AVG_PROD_W'(RECIP_W'(AVG_RECIP));
        end
    end

    assign latest  = mm4_reg;
    assign average = avg_prod_reg[AVG_SHIFT +: MM_W];

endmodule

`default_nettype wire

### rtl/core/ultrasonic_range_averager.sv
// Top level of the ultrasonic range averager: configuration, pipeline control
// and output register. Depends on urav_pkg, the stage modules and the macro header.
//
//   Channel   Direction  Handshake              Contents
//   s_*       in         s_tvalid / s_tready    one echo sample per microsecond tick
//   m_*       out        m_tvalid / m_tready    trigger, sample flag, latest, average
//   cfg_*     in         cfg_we                 enable, period_ticks, pulse_ticks
//
// One tick is taken per cycle while s_tready is high; its result passes through
// four pipeline stages into the output register.
// Reset is immediate: the distance ring is held in flip-flops and cleared at once.
// A stall on the output fills empty stages first; s_tready drops only when
// every stage and the output register hold a tick.
`default_nettype none
`include "ultrasonic_range_averager_macros.svh"

module ultrasonic_range_averager #(
    parameter int AVG_DEPTH = 10,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] echo_level, [7:1] zero
    input  logic [urav_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] trigger_level, [1] sample_valid, [15:2] latest_mm, [29:16] average_mm
    output logic [urav_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [urav_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [urav_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import urav_pkg::*;

    localparam int RAW_W = COUNT_WIDTH - 2;

    trig_cfg_t              cfg_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   v4_reg;
    logic                   m_valid_reg;
    logic                   en1;
    logic                   en2;
    logic                   en3;
    logic                   en4;
    logic                   en_out;
    logic                   accept;
    tick_tag_t              tag1_reg;
    tick_tag_t              tag2_reg;
    tick_tag_t              tag3_reg;
    tick_tag_t              tag4_reg;
    logic [COUNT_WIDTH-1:0] width1_reg;
    logic                   trig;
    logic                   done;
    logic [COUNT_WIDTH-1:0] width;
    logic [RAW_W-1:0]       mm_raw;
    logic [MM_W-1:0]        latest;
    logic [MM_W-1:0]        average;
    logic                   out_trig_reg;
    logic                   out_sample_reg;
    logic [MM_W-1:0]        out_latest_reg;
    logic [MM_W-1:0]        out_avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.period <= PERIOD_RESET;
            cfg_reg.pulse  <= PULSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE: cfg_reg.enable <= cfg_data[0];
                REG_PERIOD: cfg_reg.period <= cfg_data[PERIOD_W-1:0];
                REG_PULSE:  cfg_reg.pulse  <= cfg_data[PULSE_W-1:0];
                default:    cfg_reg.enable <= cfg_reg.enable;
            endcase
        end
    end

    assign en_out   = ~m_valid_reg | m_tready;
    assign en4      = ~v4_reg | en_out;
    assign en3      = ~v3_reg | en4;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign s_tready = en1;
    assign accept   = s_tvalid & en1;

    urav_trigger_gen u_trigger (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (accept),
        .trig  (trig)
    );

    urav_echo_timer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_echo (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .echo  (s_tdata[0]),
        .done  (done),
        .width (width)
    );

    urav_range_conv #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_conv (
        .clk    (clk),
        .load   (en2),
        .width  (width1_reg),
        .mm_raw (mm_raw)
    );

    urav_ring_avg #(
        .AVG_DEPTH (AVG_DEPTH),
        .RAW_W     (RAW_W)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (en3 & v2_reg),
        .upd_done (tag2_reg.done),
        .mm_raw   (mm_raw),
        .load_avg (en4),
        .latest   (latest),
        .average  (average)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            tag1_reg    <= '0;
            tag2_reg    <= '0;
            tag3_reg    <= '0;
            tag4_reg    <= '0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg   <= s_tvalid;
                tag1_reg <= '{trig: trig, done: done};
            end
            if (en2)
            begin
                v2_reg   <= v1_reg;
                tag2_reg <= tag1_reg;
            end
            if (en3)
            begin
                v3_reg   <= v2_reg;
                tag3_reg <= tag2_reg;
            end
            if (en4)
            begin
                v4_reg   <= v3_reg;
                tag4_reg <= tag3_reg;
            end
            if (en_out)
            begin
                m_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            width1_reg <= width;
        end
    end

    // The latest and average fields keep the last reported values between samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_trig_reg   <= 1'b0;
            out_sample_reg <= 1'b0;
            out_latest_reg <= '0;
            out_avg_reg    <= '0;
        end
        else if (en_out && v4_reg)
        begin
            out_trig_reg   <= tag4_reg.trig;
            out_sample_reg <= tag4_reg.done;
            if (tag4_reg.done)
            begin
                out_latest_reg <= latest;
                out_avg_reg    <= average;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_avg_reg, out_latest_reg, out_sample_reg, out_trig_reg};

    `URAV_ASSERT_IMP(a_ready_when_out_empty, !m_tvalid, s_tready)
    `URAV_ASSERT_IMP(a_latest_in_range, m_tvalid, m_tdata[15:2] <= MM_MAX)
    `URAV_ASSERT_IMP(a_average_in_range, m_tvalid, m_tdata[29:16] <= MM_MAX)
    `URAV_ASSERT_NXT(a_drain_when_empty, m_tvalid && m_tready && !v4_reg, !m_tvalid)

endmodule

`default_nettype wire
